### src/lzwe_pkg.sv
package lzwe_pkg;

    localparam int DICT_ENTRIES_DEF  = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    localparam int CODE_CLEAR = 256;
    localparam int CODE_EOI   = 257;
    localparam int FIRST_FREE = 258;
    localparam int MIN_BITS   = 9;

    typedef enum logic [1:0] {
        PUT_CLEAR  = 2'd0,
        PUT_PREFIX = 2'd1,
        PUT_EOI    = 2'd2
    } t_put;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_PLAN   = 7'b0000100,
        S_PUT    = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_PAD    = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic search_start;
        logic put_en;
        t_put put_sel;
        logic drain_en;
        logic pad_en;
        logic last;
        logic eos;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic pv;
        logic search_done;
        logic found;
        logic clear_full;
        logic cnt_ge8;
        logic cnt_lt16;
        logic cnt_eq8;
        logic cnt_nz;
        logic out_free;
    } t_stat;

endpackage

### src/lzwe_ctrl.sv
module lzwe_ctrl
    import lzwe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_s_tuser,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_mask, n_mask;
    logic       r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
            r_cmd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_cmd   <= n_cmd;
        end
    end

    // mask order: start clear, prefix, eoi, full clear
    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_cmd      = r_cmd;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cmd      = i_s_tuser;
                    if (!i_s_tuser && i_stat.pv) begin
                        o_cmd.search_start = 1'b1;
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_PLAN;
                    end
                end
            end
            S_SEARCH: begin
                if (i_stat.search_done) n_state = S_PLAN;
            end
            S_PLAN: begin
                n_mask = {(!r_cmd && i_stat.pv && !i_stat.found && i_stat.clear_full),
                          r_cmd,
                          (r_cmd ? i_stat.pv : (i_stat.pv && !i_stat.found)),
                          !i_stat.started};
                n_state = (n_mask != 4'd0) ? S_PUT : S_FIN;
            end
            S_PUT: begin
                o_cmd.put_en = 1'b1;
                if (r_mask[0]) begin
                    o_cmd.put_sel = PUT_CLEAR;
                    n_mask[0] = 1'b0;
                end else if (r_mask[1]) begin
                    o_cmd.put_sel = PUT_PREFIX;
                    n_mask[1] = 1'b0;
                end else if (r_mask[2]) begin
                    o_cmd.put_sel = PUT_EOI;
                    n_mask[2] = 1'b0;
                end else begin
                    o_cmd.put_sel = PUT_CLEAR;
                    n_mask[3] = 1'b0;
                end
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_stat.cnt_ge8) begin
                    if (i_stat.out_free) begin
                        o_cmd.drain_en = 1'b1;
                        o_cmd.last = i_stat.cnt_lt16 && (r_mask == 4'd0) &&
                                     !(r_cmd && !i_stat.cnt_eq8);
                        o_cmd.eos  = o_cmd.last && r_cmd;
                    end
                end else if (r_mask != 4'd0) begin
                    n_state = S_PUT;
                end else if (r_cmd && i_stat.cnt_nz) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PAD: begin
                if (i_stat.out_free) begin
                    o_cmd.pad_en = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.eos    = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### src/lzwe_dp.sv
module lzwe_dp
    import lzwe_pkg::*;
#(
    parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tuser,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast,
    output logic       o_m_tuser
);

    localparam int AW    = $clog2(DICT_ENTRIES);
    localparam int CB    = MAX_CODE_BITS;
    localparam int ACC_W = CB + 8;
    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam int PW    = ((AW > CB) ? AW : CB) + 2;

    logic [CB+7:0]    mem [DICT_ENTRIES];

    logic [7:0]       r_byte;
    logic             r_cmd;
    logic [AW:0]      r_nfc;
    logic [3:0]       r_cw;
    logic [CB-1:0]    r_prefix;
    logic             r_pv;
    logic             r_started;
    logic [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;

    logic             r_scan;
    logic [AW:0]      r_addr;
    logic [AW-1:0]    r_raddr;
    logic             r_rv;
    logic [CB+7:0]    r_rdata;
    logic             r_found;
    logic [CB-1:0]    r_fcode;

    logic             r_ov;
    logic [7:0]       r_obyte;
    logic             r_olast;
    logic             r_oeos;

    logic [CB+7:0]    key;
    logic             hit;
    logic             done;
    logic [PW-1:0]    nfc1;
    logic [PW-1:0]    pow;
    logic             clear_full;
    logic             grow;
    logic [CB-1:0]    cv;
    logic [ACC_W-1:0] placed;
    logic             out_free;
    logic             add;

    assign key  = {r_prefix, r_byte};
    assign hit  = r_scan && r_rv && (r_rdata == key);
    assign done = r_scan && (hit || (!r_rv && (r_addr >= r_nfc)));
    assign nfc1 = PW'(r_nfc) + PW'(1);
    assign pow  = PW'(1) << r_cw;
    assign clear_full = (nfc1 >= PW'(DICT_ENTRIES)) ||
                        ((nfc1 >= pow) && (r_cw >= 4'(CB)));
    assign grow = !clear_full && (nfc1 >= pow);
    assign out_free = !r_ov || i_m_tready;
    assign add  = i_cmd.fin && !r_cmd && r_pv && !r_found;

    always_comb begin
        case (i_cmd.put_sel)
            PUT_CLEAR:  cv = CB'(CODE_CLEAR);
            PUT_PREFIX: cv = r_prefix;
            PUT_EOI:    cv = CB'(CODE_EOI);
            default:    cv = CB'(CODE_CLEAR);
        endcase
        placed = ({cv, 8'd0} << (4'(CB) - r_cw)) >> r_cnt;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_addr[AW-1:0]];
        if (add) mem[r_nfc[AW-1:0]] <= key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfc     <= (AW+1)'(FIRST_FREE);
            r_cw      <= 4'(MIN_BITS);
            r_prefix  <= '0;
            r_pv      <= 1'b0;
            r_started <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_scan    <= 1'b0;
            r_rv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cmd.search_start) begin
                r_scan <= 1'b1;
                r_addr <= (AW+1)'(FIRST_FREE);
                r_rv   <= 1'b0;
            end else if (done) begin
                r_scan  <= 1'b0;
                r_rv    <= 1'b0;
                r_found <= hit;
                r_fcode <= CB'(r_raddr);
            end else if (r_scan) begin
                if (r_addr < r_nfc) begin
                    r_rv    <= 1'b1;
                    r_raddr <= r_addr[AW-1:0];
                    r_addr  <= r_addr + (AW+1)'(1);
                end else begin
                    r_rv <= 1'b0;
                end
            end

            if (i_cmd.put_en) begin
                r_acc <= r_acc | placed;
                r_cnt <= r_cnt + CNT_W'(r_cw);
            end else if (i_cmd.drain_en) begin
                r_acc <= r_acc << 8;
                r_cnt <= r_cnt - CNT_W'(8);
            end else if (i_cmd.pad_en) begin
                r_acc <= '0;
                r_cnt <= '0;
            end

            if (i_cmd.drain_en || i_cmd.pad_en) begin
                r_ov    <= 1'b1;
                r_obyte <= r_acc[ACC_W-1 -: 8];
                r_olast <= i_cmd.last;
                r_oeos  <= i_cmd.eos;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end

            if (i_cmd.fin) begin
                if (r_cmd) begin
                    r_nfc     <= (AW+1)'(FIRST_FREE);
                    r_cw      <= 4'(MIN_BITS);
                    r_prefix  <= '0;
                    r_pv      <= 1'b0;
                    r_started <= 1'b0;
                end else begin
                    r_started <= 1'b1;
                    if (!r_pv) begin
                        r_prefix <= CB'(r_byte);
                        r_pv     <= 1'b1;
                    end else if (r_found) begin
                        r_prefix <= r_fcode;
                    end else begin
                        r_prefix <= CB'(r_byte);
                        if (clear_full) begin
                            r_nfc <= (AW+1)'(FIRST_FREE);
                            r_cw  <= 4'(MIN_BITS);
                        end else begin
                            r_nfc <= r_nfc + (AW+1)'(1);
                            if (grow) r_cw <= r_cw + 4'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_s_tdata;
            r_cmd  <= i_s_tuser;
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.started     = r_started;
        o_stat.pv          = r_pv;
        o_stat.search_done = done;
        o_stat.found       = r_found;
        o_stat.clear_full  = clear_full;
        o_stat.cnt_ge8     = (r_cnt >= CNT_W'(8));
        o_stat.cnt_lt16    = (r_cnt < CNT_W'(16));
        o_stat.cnt_eq8     = (r_cnt == CNT_W'(8));
        o_stat.cnt_nz      = (r_cnt != '0);
        o_stat.out_free    = out_free;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oeos;

`ifndef SYNTHESIS
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_en |-> (r_cnt < CNT_W'(8)))
        else $error("code put with a full byte pending");
    a_drain_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.drain_en || i_cmd.pad_en) |-> (out_free && (r_cnt != '0)))
        else $error("byte emitted without room or bits");
    a_nfc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add |-> (r_nfc < (AW+1)'(DICT_ENTRIES)))
        else $error("dictionary write past end");
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oeos) |-> r_olast)
        else $error("end of stream without last");
`endif

endmodule

### src/tiff_lzw_encoder.sv
// channel | dir | tdata             | tuser          | tlast
// s       | in  | [7:0] data_byte   | command        | -
// m       | out | [7:0] out_byte    | end_of_stream  | last_of_run
//
// An item is loaded and planned and, when a string is pending, the dictionary
// entries from 258 to next_free_code - 1 are scanned over the single memory
// read port; then each code is put and drained as output bytes (up to 4 bytes).
// Reset is synchronous and clears no memory; the block is ready at once.
// A stalled output holds the controller in its drain or pad state; a new item
// is taken while the last byte still waits in the output register.
module tiff_lzw_encoder
    import lzwe_pkg::*;
#(
    parameter int DICT_ENTRIES  = DICT_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tuser,   // command
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,
    output logic       o_m_tuser    // end_of_stream
);

    t_cmd  cmd;
    t_stat stat;

    lzwe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lzwe_dp #(
        .DICT_ENTRIES  (DICT_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
